@@ hdl/olist_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the ordered list engine.
package olist_pkg;

  parameter int unsigned DefListDepth = 16;
  parameter int unsigned ValueWidth   = 32;
  parameter int unsigned LengthWidth  = 5;

  typedef enum logic [1:0] {
    OpAppend   = 2'd0,
    OpDelHead  = 2'd1,
    OpDelTail  = 2'd2,
    OpDelAfter = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StatOk          = 2'd0,
    StatEmpty       = 2'd1,
    StatNotPossible = 2'd2,
    StatFull        = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]                   operation;
    logic signed [ValueWidth-1:0] item_value;
  } olist_in_t;

  typedef struct packed {
    logic [1:0]                   status;
    logic signed [ValueWidth-1:0] removed_value;
    logic [LengthWidth-1:0]       list_length;
  } olist_out_t;

endpackage

@@ hdl/olist_ctrl.sv @@
`timescale 1ns / 1ps
// Entry memory and sequencer that searches and shifts one entry per cycle.
module olist_ctrl #(
  parameter int unsigned ListDepth = olist_pkg::DefListDepth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  olist_pkg::olist_in_t   in_item_i,
  output logic                   res_valid_o,
  input  logic                   res_take_i,
  output olist_pkg::olist_out_t  res_o
);
  import olist_pkg::*;

  localparam int unsigned AW = $clog2(ListDepth);
  localparam int unsigned CW = $clog2(ListDepth + 1);

  typedef enum logic [1:0] {
    StIdle,
    StSearch,
    StShift,
    StDone
  } state_e;

  state_e                  state_q;
  logic [CW-1:0]           count_q;
  logic [AW-1:0]           ptr_q;
  logic                    first_q;
  logic [ValueWidth-1:0]   val_q;
  status_e                 status_q;
  logic [ValueWidth-1:0]   removed_q;

  logic [ValueWidth-1:0]   mem_q [ListDepth];
  logic [ValueWidth-1:0]   rd_data_q;

  logic [AW-1:0]           rd_addr;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic [ValueWidth-1:0]   wr_data;

  logic [CW-1:0]           ptr_nx;
  logic [CW-1:0]           count_m1;
  logic                    last;
  logic                    full;
  logic                    empty;
  op_e                     op;

  assign ptr_nx   = CW'(ptr_q) + 1'b1;
  assign count_m1 = count_q - 1'b1;
  assign last     = (CW'(ptr_q) == count_m1);
  assign full     = (count_q == CW'(ListDepth));
  assign empty    = (count_q == '0);
  assign op       = op_e'(in_item_i.operation);

  always_comb begin
    rd_addr = AW'(ptr_nx);
    wr_en   = 1'b0;
    wr_addr = AW'(count_q);
    wr_data = in_item_i.item_value;
    unique case (state_q)
      StIdle: begin
        unique case (op)
          OpAppend: begin
            wr_en   = in_valid_i && !full;
            rd_addr = '0;
          end
          OpDelTail: rd_addr = AW'(count_m1);
          OpDelHead, OpDelAfter: rd_addr = '0;
          default: rd_addr = '0;
        endcase
      end
      StShift: begin
        if (!first_q) begin
          wr_en   = 1'b1;
          wr_addr = ptr_q - 1'b1;
          wr_data = rd_data_q;
        end
      end
      StSearch, StDone: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      count_q   <= '0;
      ptr_q     <= '0;
      first_q   <= 1'b0;
      val_q     <= '0;
      status_q  <= StatOk;
      removed_q <= '0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            val_q     <= in_item_i.item_value;
            removed_q <= '0;
            first_q   <= 1'b1;
            unique case (op)
              OpAppend: begin
                if (full) begin
                  status_q <= StatFull;
                end else begin
                  status_q <= StatOk;
                  count_q  <= count_q + 1'b1;
                end
                state_q <= StDone;
              end
              OpDelHead: begin
                ptr_q <= '0;
                if (empty) begin
                  status_q <= StatEmpty;
                  state_q  <= StDone;
                end else begin
                  status_q <= StatOk;
                  state_q  <= StShift;
                end
              end
              OpDelTail: begin
                ptr_q <= AW'(count_m1);
                if (empty) begin
                  status_q <= StatEmpty;
                  state_q  <= StDone;
                end else begin
                  status_q <= StatOk;
                  state_q  <= StShift;
                end
              end
              OpDelAfter: begin
                ptr_q <= '0;
                if (empty) begin
                  status_q <= StatNotPossible;
                  state_q  <= StDone;
                end else begin
                  state_q <= StSearch;
                end
              end
              default: state_q <= StIdle;
            endcase
          end
        end
        StSearch: begin
          if (last) begin
            status_q <= StatNotPossible;
            state_q  <= StDone;
          end else begin
            ptr_q <= AW'(ptr_nx);
            if (rd_data_q == val_q) begin
              status_q <= StatOk;
              first_q  <= 1'b1;
              state_q  <= StShift;
            end
          end
        end
        StShift: begin
          first_q <= 1'b0;
          if (first_q) begin
            removed_q <= rd_data_q;
          end
          if (last) begin
            count_q <= count_m1;
            state_q <= StDone;
          end else begin
            ptr_q <= AW'(ptr_nx);
          end
        end
        StDone: begin
          if (res_take_i) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign in_stall_o          = (state_q != StIdle);
  assign res_valid_o         = (state_q == StDone);
  assign res_o.status        = status_q;
  assign res_o.removed_value = removed_q;
  assign res_o.list_length   = LengthWidth'(count_q);

endmodule

@@ hdl/ordered_list_engine_top.sv @@
`timescale 1ns / 1ps
// Ordered list engine: bounded list with append and three kinds of removal.
//
// Input channel in_valid_i / in_stall_o carries one item: an operation and a
// value. Output channel out_valid_o / out_stall_i returns one item per input
// item: status, removed value and the new list length. An item moves at a
// rising edge with valid high and stall low.
// Only one item is worked on at a time; in_stall_o is high until its result
// has moved into the output register, which can then hold it while the next
// item is already accepted.
// Append, and a removal from an empty list, go straight to the result state;
// remove tail reads the last entry only; remove head and remove after value
// step through every entry of the list before the result is ready.
// out_valid_o rises at the edge that frees the sequencer for the next item.
// Remove after value searches up to the first match and then shifts the rest,
// one entry per cycle, so it visits every entry whether or not it matches.
// Reset empties the list; entry contents are not cleared and need no pass.
// A stalled result stays in the output register, and the sequencer holds the
// next finished result until that register frees up.
module ordered_list_engine_top #(
  parameter int unsigned LIST_DEPTH = olist_pkg::DefListDepth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  olist_pkg::olist_in_t   in_item_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output olist_pkg::olist_out_t  out_item_o
);
  import olist_pkg::*;

  logic       res_valid;
  logic       res_take;
  olist_out_t res;
  logic       out_valid_q;
  olist_out_t out_item_q;

  olist_ctrl #(
    .ListDepth(LIST_DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .res_valid_o(res_valid),
    .res_take_i (res_take),
    .res_o      (res)
  );

  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
